### design/rmq_pkg.sv
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion: shared package
// Fixed-point format, field widths, the branch code and the item types that
// travel between the front (classify + queue) and the back (arithmetic).
// ----------------------------------------------------------------------------
`default_nettype none

package rmq_pkg;

  // Number format: signed Q2.30 on every port field.
  localparam int unsigned FRAC_BITS = 30;
  localparam int unsigned IN_W      = 32;
  localparam int unsigned N_IN      = 9;
  localparam int unsigned IN_TDATA_W = N_IN * IN_W;

  // Off-diagonal sums and differences need one more bit than an input.
  localparam int unsigned NUM_W = IN_W + 1;
  // A positive radicand stays below 2^33.
  localparam int unsigned RAD_W = 33;

  // Square root unit: 64-bit radicand, 32-bit root, one root bit per stage.
  localparam int unsigned SQ_IN_W   = 64;
  localparam int unsigned ROOT_W    = 32;
  localparam int unsigned SQ_STAGES = ROOT_W;

  // Divider: 33-bit magnitude and divisor, 32 quotient bits, one per stage.
  localparam int unsigned Q_W       = 32;
  localparam int unsigned DIV_D_W   = 33;
  localparam int unsigned DIV_STEPS = Q_W;

  // Squared norm.
  localparam int unsigned SQR_W  = 2 * Q_W - 1;
  localparam int unsigned NORM_W = 64;

  localparam int unsigned OUT_TDATA_W = 4 * Q_W;
  localparam int unsigned OUT_TUSER_W = 3;

  localparam logic signed [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
  localparam logic signed [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};
  localparam logic signed [Q_W-1:0] Q_ONE = Q_W'(1) << FRAC_BITS;
  localparam logic [NORM_W-1:0] NORM_UNIT = NORM_W'(1) << (2 * FRAC_BITS);

  // Which Shepperd branch produced the quaternion.
  typedef enum logic [1:0] {
    BR_TRACE = 2'd0,
    BR_X     = 2'd1,
    BR_Y     = 2'd2,
    BR_Z     = 2'd3
  } branch_t;

  // Classified item: radicand, the three numerators in ascending component
  // order (the component taken from the root is skipped), branch and flag.
  typedef struct packed {
    logic [RAD_W-1:0]            rad;
    logic [2:0][NUM_W-1:0]       num;
    branch_t                     branch;
    logic                        bad;
  } fe_item_t;

  // Head of the queue as seen by the back end.
  typedef struct packed {
    logic     valid;
    fe_item_t item;
  } fe_head_t;

endpackage

`default_nettype wire

### design/rmq_front.sv
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion: front end
// Picks the branch, forms the radicand and the numerators, and queues the
// classified item for the back end in a two-entry queue.
// ----------------------------------------------------------------------------
`default_nettype none

module rmq_front (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [rmq_pkg::IN_TDATA_W-1:0]   in_data,
  input  wire logic                             pop,
  output rmq_pkg::fe_head_t                     head
);

  localparam int unsigned IW    = rmq_pkg::IN_W;
  localparam int unsigned NW    = rmq_pkg::NUM_W;
  localparam int unsigned SW    = IW + 4;
  localparam int unsigned QD    = 2;
  localparam int unsigned PTR_W = $clog2(QD);
  localparam int unsigned CNT_W = $clog2(QD + 1);
  localparam logic signed [SW-1:0] ONE_S = SW'(1) << rmq_pkg::FRAC_BITS;

  logic signed [IW-1:0] ix, iy, iz, jx, jy, jz, kx, ky, kz;
  logic signed [SW-1:0] xi, yj, zk, trace, rad;
  logic [NW-1:0]        d_jz_ky, d_kx_iz, d_iy_jx, s_jx_iy, s_iz_kx, s_ky_jz;
  rmq_pkg::fe_item_t    item;
  logic                 push;

  rmq_pkg::fe_item_t    mem_r [QD];
  logic [PTR_W-1:0]     wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;

  // Unpack the nine matrix elements.
  assign ix = in_data[0*IW +: IW];
  assign iy = in_data[1*IW +: IW];
  assign iz = in_data[2*IW +: IW];
  assign jx = in_data[3*IW +: IW];
  assign jy = in_data[4*IW +: IW];
  assign jz = in_data[5*IW +: IW];
  assign kx = in_data[6*IW +: IW];
  assign ky = in_data[7*IW +: IW];
  assign kz = in_data[8*IW +: IW];

  assign xi    = SW'(ix);
  assign yj    = SW'(jy);
  assign zk    = SW'(kz);
  assign trace = xi + yj + zk + ONE_S;

  // Off-diagonal sums and differences, exact in one extra bit.
  assign d_jz_ky = NW'(jz) - NW'(ky);
  assign d_kx_iz = NW'(kx) - NW'(iz);
  assign d_iy_jx = NW'(iy) - NW'(jx);
  assign s_jx_iy = NW'(jx) + NW'(iy);
  assign s_iz_kx = NW'(iz) + NW'(kx);
  assign s_ky_jz = NW'(ky) + NW'(jz);

  // Branch choice: trace first, then the largest diagonal by strict compares.
  always_comb begin
    if (!trace[SW-1] && (trace != '0)) begin
      item.branch = rmq_pkg::BR_TRACE;
      rad         = trace;
      item.num    = {d_iy_jx, d_kx_iz, d_jz_ky};
    end else if ((ix > jy) && (ix > kz)) begin
      item.branch = rmq_pkg::BR_X;
      rad         = ONE_S + xi - yj - zk;
      item.num    = {d_jz_ky, s_iz_kx, s_jx_iy};
    end else if (jy > kz) begin
      item.branch = rmq_pkg::BR_Y;
      rad         = ONE_S + yj - xi - zk;
      item.num    = {d_kx_iz, s_ky_jz, s_jx_iy};
    end else begin
      item.branch = rmq_pkg::BR_Z;
      rad         = ONE_S + zk - xi - yj;
      item.num    = {d_iy_jx, s_ky_jz, s_iz_kx};
    end
    item.rad = rad[rmq_pkg::RAD_W-1:0];
    item.bad = rad[SW-1] || (rad == '0);
  end

  // Two-entry queue between the front and the back.
  assign in_ready = (cnt_r != CNT_W'(QD));
  assign push     = in_valid && in_ready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= item;
    end
  end

  assign head.valid = (cnt_r != '0);
  assign head.item  = mem_r[rd_ptr_r];

  // The queue never holds more than its depth.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(QD))
    else $error("queue count above depth");

  // The back end only takes an item that is there.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (cnt_r != '0))
    else $error("pop from empty queue");

endmodule

`default_nettype wire

### design/rmq_sqrt.sv
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion: pipelined square root
// floor(sqrt(x)) of a 64-bit value, one root bit per stage, 32 stages.
// ----------------------------------------------------------------------------
`default_nettype none

module rmq_sqrt (
  input  wire logic                           clk,
  input  wire logic                           en,
  input  wire logic [rmq_pkg::SQ_IN_W-1:0]    radicand,
  output logic      [rmq_pkg::ROOT_W-1:0]     root
);

  localparam int unsigned XW    = rmq_pkg::SQ_IN_W;
  localparam int unsigned RW    = rmq_pkg::ROOT_W;
  localparam int unsigned REM_W = RW + 4;
  localparam int unsigned NS    = rmq_pkg::SQ_STAGES;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [RW-1:0]    root;
  } sq_state_t;

  // One digit of the restoring square root.
  function automatic sq_state_t sqrt_step(sq_state_t s, logic [1:0] bits);
    logic [REM_W-1:0] cur;
    logic [REM_W-1:0] trial;
    sq_state_t        r;
    cur   = {s.rem[REM_W-3:0], bits};
    trial = REM_W'({s.root, 2'b01});
    if (cur >= trial) begin
      r.rem  = cur - trial;
      r.root = {s.root[RW-2:0], 1'b1};
    end else begin
      r.rem  = cur;
      r.root = {s.root[RW-2:0], 1'b0};
    end
    return r;
  endfunction

  sq_state_t      st_r [NS];
  logic [XW-1:0]  x_r  [NS-1];

  // Stage k consumes the next two radicand bits.
  for (genvar k = 0; k < NS; k++) begin : g_stage
    sq_state_t     st_in;
    logic [XW-1:0] x_in;
    if (k == 0) begin : g_first
      assign st_in = '0;
      assign x_in  = radicand;
    end else begin : g_next
      assign st_in = st_r[k-1];
      assign x_in  = x_r[k-1];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        st_r[k] <= sqrt_step(st_in, x_in[XW-1 -: 2]);
      end
    end
    if (k < NS - 1) begin : g_shift
      always_ff @(posedge clk) begin
        if (en) begin
          x_r[k] <= {x_in[XW-3:0], 2'b00};
        end
      end
    end
  end

  assign root = st_r[NS-1].root;

endmodule

`default_nettype wire

### design/rmq_div.sv
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion: pipelined fixed-point divider
// Gives sat32(trunc(num * 2^30 / dvsr)): an entry stage checks for overflow,
// then 32 restoring stages produce one quotient bit each.
// ----------------------------------------------------------------------------
`default_nettype none

module rmq_div (
  input  wire logic                                clk,
  input  wire logic                                en,
  input  wire logic signed [rmq_pkg::NUM_W-1:0]    num,
  input  wire logic        [rmq_pkg::DIV_D_W-1:0]  dvsr,
  output logic signed      [rmq_pkg::Q_W-1:0]      quo
);

  localparam int unsigned NW    = rmq_pkg::NUM_W;
  localparam int unsigned DW    = rmq_pkg::DIV_D_W;
  localparam int unsigned QW    = rmq_pkg::Q_W;
  localparam int unsigned REM_W = DW + 2;
  localparam int unsigned NS    = rmq_pkg::DIV_STEPS;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [QW-1:0]    q;
  } dv_state_t;

  // One restoring division step.
  function automatic dv_state_t div_step(dv_state_t s, logic bit_in, logic [DW-1:0] d);
    logic [REM_W-1:0] cur;
    dv_state_t        r;
    cur = {s.rem[REM_W-2:0], bit_in};
    if (cur >= REM_W'(d)) begin
      r.rem = cur - REM_W'(d);
      r.q   = {s.q[QW-2:0], 1'b1};
    end else begin
      r.rem = cur;
      r.q   = {s.q[QW-2:0], 1'b0};
    end
    return r;
  endfunction

  logic [NW-1:0]    mag;
  logic             ovf;
  dv_state_t        st_r  [NS+1];
  logic             neg_r [NS+1];
  logic             ovf_r [NS+1];
  logic [DW-1:0]    d_r   [NS];
  logic [1:0]       lo_r;
  logic             lo1_r;
  logic [QW-1:0]    qf;

  // The quotient fits 32 bits exactly when mag < 4 * dvsr.
  assign mag = num[NW-1] ? (-num) : num;
  assign ovf = ({2'b00, mag} >= {dvsr, 2'b00});

  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0]  <= '{rem: REM_W'(mag >> 2), q: '0};
      neg_r[0] <= num[NW-1];
      ovf_r[0] <= ovf;
      d_r[0]   <= dvsr;
      lo_r     <= mag[1:0];
      lo1_r    <= lo_r[0];
    end
  end

  // Only the two lowest magnitude bits enter after the entry stage.
  for (genvar k = 0; k < NS; k++) begin : g_step
    logic bit_in;
    if (k == 0) begin : g_b0
      assign bit_in = lo_r[1];
    end else if (k == 1) begin : g_b1
      assign bit_in = lo1_r;
    end else begin : g_bz
      assign bit_in = 1'b0;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        st_r[k+1]  <= div_step(st_r[k], bit_in, d_r[k]);
        neg_r[k+1] <= neg_r[k];
        ovf_r[k+1] <= ovf_r[k];
      end
    end
    if (k < NS - 1) begin : g_d
      always_ff @(posedge clk) begin
        if (en) begin
          d_r[k+1] <= d_r[k];
        end
      end
    end
  end

  // Apply the sign and saturate to the signed 32-bit range.
  assign qf = st_r[NS].q;
  always_comb begin
    if (ovf_r[NS]) begin
      quo = neg_r[NS] ? rmq_pkg::Q_MIN : rmq_pkg::Q_MAX;
    end else if (!neg_r[NS]) begin
      quo = qf[QW-1] ? rmq_pkg::Q_MAX : signed'(qf);
    end else if (qf[QW-1] && (|qf[QW-2:0])) begin
      quo = rmq_pkg::Q_MIN;
    end else begin
      quo = signed'(-qf);
    end
  end

endmodule

`default_nettype wire

### design/rmq_back.sv
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion: back end
// Root of the radicand, three divisions by the scale, squared norm, root of
// the norm, four normalizing divisions and the output register. The whole
// pipeline advances together when the output register can move.
// ----------------------------------------------------------------------------
`default_nettype none

module rmq_back (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  rmq_pkg::fe_head_t                       head,
  output logic                                    pop,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [rmq_pkg::OUT_TDATA_W-1:0]         out_data,
  output logic [rmq_pkg::OUT_TUSER_W-1:0]         out_user
);

  localparam int unsigned QW      = rmq_pkg::Q_W;
  localparam int unsigned NW      = rmq_pkg::NUM_W;
  localparam int unsigned RW      = rmq_pkg::ROOT_W;
  localparam int unsigned SQ_LAT  = rmq_pkg::SQ_STAGES;
  localparam int unsigned DIV_LAT = rmq_pkg::DIV_STEPS + 1;
  localparam int unsigned LAT     = 2 * SQ_LAT + 2 * DIV_LAT + 4;

  typedef struct packed {
    logic [2:0][NW-1:0] num;
    rmq_pkg::branch_t   branch;
    logic               bad;
  } s1_t;

  typedef struct packed {
    logic [QW-1:0]      half;
    rmq_pkg::branch_t   branch;
    logic               bad;
  } s2_t;

  typedef struct packed {
    logic [3:0][QW-1:0] q;
    rmq_pkg::branch_t   branch;
    logic               bad;
  } qv_t;

  typedef struct packed {
    logic [3:0][QW-1:0] q;
    rmq_pkg::branch_t   branch;
    logic               bad;
    logic               unit;
    logic               zero;
  } s4_t;

  logic                    en;
  logic [LAT-1:0]          vld_r;

  logic [RW-1:0]           root1, root2;
  logic signed [QW-1:0]    quo1 [3];
  logic signed [QW-1:0]    quo2 [4];

  s1_t                     s1_r [SQ_LAT];
  s2_t                     s2_r [DIV_LAT];
  qv_t                     qa_nxt, qa_r, qb_r, qc_r;
  logic signed [2*QW-1:0]  prod [4];
  logic [rmq_pkg::SQR_W-1:0]    sqr_r [4];
  logic [rmq_pkg::NORM_W:0]     nsum;
  logic [rmq_pkg::NORM_W-1:0]   n_r;
  s4_t                     s4_r [SQ_LAT];
  s4_t                     s5_r [DIV_LAT];
  s4_t                     fin;
  logic                    bad_f;
  logic [3:0][QW-1:0]      qo;
  logic [rmq_pkg::OUT_TDATA_W-1:0] out_data_r, out_data_nxt;
  logic [rmq_pkg::OUT_TUSER_W-1:0] out_user_r, out_user_nxt;

  // Pipeline control: everything moves when the output register is free.
  assign en  = !vld_r[LAT-1] || out_ready;
  assign pop = en && head.valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], pop};
    end
  end

  // Root of the radicand scaled by 2^30.
  rmq_sqrt u_sqrt_rad (
    .clk      (clk),
    .en       (en),
    .radicand (rmq_pkg::SQ_IN_W'({head.item.rad, rmq_pkg::FRAC_BITS'(0)})),
    .root     (root1)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r[0] <= '{num: head.item.num, branch: head.item.branch, bad: head.item.bad};
      for (int i = 1; i < SQ_LAT; i++) begin
        s1_r[i] <= s1_r[i-1];
      end
    end
  end

  // Numerators divided by scale = 2 * root.
  for (genvar c = 0; c < 3; c++) begin : g_div1
    rmq_div u_div (
      .clk  (clk),
      .en   (en),
      .num  ($signed(s1_r[SQ_LAT-1].num[c])),
      .dvsr ({root1, 1'b0}),
      .quo  (quo1[c])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_r[0] <= '{half: QW'(root1 >> 1), branch: s1_r[SQ_LAT-1].branch,
                   bad: s1_r[SQ_LAT-1].bad};
      for (int i = 1; i < DIV_LAT; i++) begin
        s2_r[i] <= s2_r[i-1];
      end
    end
  end

  // Put the components in quaternion order for the chosen branch.
  always_comb begin
    qa_nxt.branch = s2_r[DIV_LAT-1].branch;
    qa_nxt.bad    = s2_r[DIV_LAT-1].bad;
    case (s2_r[DIV_LAT-1].branch)
      rmq_pkg::BR_TRACE: begin
        qa_nxt.q = {s2_r[DIV_LAT-1].half, quo1[2], quo1[1], quo1[0]};
      end
      rmq_pkg::BR_X: begin
        qa_nxt.q = {quo1[2], quo1[1], quo1[0], s2_r[DIV_LAT-1].half};
      end
      rmq_pkg::BR_Y: begin
        qa_nxt.q = {quo1[2], quo1[1], s2_r[DIV_LAT-1].half, quo1[0]};
      end
      default: begin
        qa_nxt.q = {quo1[2], s2_r[DIV_LAT-1].half, quo1[1], quo1[0]};
      end
    endcase
  end

  // Squares of the four components.
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      prod[c] = $signed(qa_r.q[c]) * $signed(qa_r.q[c]);
    end
  end

  // Squared norm, saturated at the top of 64 bits.
  assign nsum = (rmq_pkg::NORM_W+1)'(sqr_r[0]) + (rmq_pkg::NORM_W+1)'(sqr_r[1])
              + (rmq_pkg::NORM_W+1)'(sqr_r[2]) + (rmq_pkg::NORM_W+1)'(sqr_r[3]);

  always_ff @(posedge clk) begin
    if (en) begin
      qa_r <= qa_nxt;
      qb_r <= qa_r;
      for (int c = 0; c < 4; c++) begin
        sqr_r[c] <= rmq_pkg::SQR_W'(prod[c]);
      end
      qc_r <= qb_r;
      n_r  <= nsum[rmq_pkg::NORM_W] ? '1 : nsum[rmq_pkg::NORM_W-1:0];
    end
  end

  // Root of the squared norm.
  rmq_sqrt u_sqrt_norm (
    .clk      (clk),
    .en       (en),
    .radicand (n_r),
    .root     (root2)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      s4_r[0] <= '{q: qc_r.q, branch: qc_r.branch, bad: qc_r.bad,
                   unit: (n_r == rmq_pkg::NORM_UNIT), zero: (n_r == '0)};
      for (int i = 1; i < SQ_LAT; i++) begin
        s4_r[i] <= s4_r[i-1];
      end
      s5_r[0] <= s4_r[SQ_LAT-1];
      for (int i = 1; i < DIV_LAT; i++) begin
        s5_r[i] <= s5_r[i-1];
      end
    end
  end

  // Normalizing divisions.
  for (genvar c = 0; c < 4; c++) begin : g_div2
    rmq_div u_div (
      .clk  (clk),
      .en   (en),
      .num  (NW'($signed(s4_r[SQ_LAT-1].q[c]))),
      .dvsr ({1'b0, root2}),
      .quo  (quo2[c])
    );
  end

  // Final selection: identity when invalid, pass-through at exact unit norm.
  assign fin   = s5_r[DIV_LAT-1];
  assign bad_f = fin.bad || fin.zero;

  always_comb begin
    if (bad_f) begin
      qo = {rmq_pkg::Q_ONE, QW'(0), QW'(0), QW'(0)};
    end else if (fin.unit) begin
      qo = fin.q;
    end else begin
      qo = {quo2[3], quo2[2], quo2[1], quo2[0]};
    end
    out_data_nxt = qo;
    out_user_nxt = {bad_f, fin.branch};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_data_nxt;
      out_user_r <= out_user_nxt;
    end
  end

  assign out_valid = vld_r[LAT-1];
  assign out_data  = out_data_r;
  assign out_user  = out_user_r;

  // An invalid result is always the identity quaternion.
  a_invalid_identity: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_user[2]) |->
      ((out_data[4*QW-1 -: QW] == rmq_pkg::Q_ONE) && (out_data[3*QW-1:0] == '0)))
    else $error("invalid result is not identity");

  // The trace branch keeps a non-negative scalar part.
  a_trace_w_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_user[2] && (out_user[1:0] == rmq_pkg::BR_TRACE)) |->
      !out_data[4*QW-1])
    else $error("negative scalar on trace branch");

endmodule

`default_nettype wire

### design/rotation_matrix_to_quaternion_top.sv
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion (Shepperd's method), fixed point
// Turns a 3x3 rotation basis in signed Q2.30 into a normalized quaternion.
//
//   Channel | Direction | Item contents
//   --------+-----------+------------------------------------------------------
//   in_     | input     | nine basis elements, Q2.30, one matrix per item
//   out_    | output    | quaternion (i, j, k, w), branch taken, invalid flag
//
// One item is accepted per cycle while the pipeline is not held; results leave in
// order, passing through two 32-stage square roots, two 33-stage dividers, three
// norm stages and the output register.
// Reset clears the queue and the pipeline valid bits; nothing else is kept.
// While a result waits with out_tready low the whole pipeline holds and the
// two-entry queue fills, after which in_tready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module rotation_matrix_to_quaternion_top (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // basis_i_x, basis_i_y, basis_i_z, basis_j_x, basis_j_y, basis_j_z,
  // basis_k_x, basis_k_y, basis_k_z (32 bits each, lowest first)
  input  wire logic [rmq_pkg::IN_TDATA_W-1:0]      in_tdata,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // quat_i, quat_j, quat_k, quat_w (32 bits each, lowest first)
  output logic [rmq_pkg::OUT_TDATA_W-1:0]          out_tdata,
  // branch_taken [1:0], invalid [2]
  output logic [rmq_pkg::OUT_TUSER_W-1:0]          out_tuser
);

  rmq_pkg::fe_head_t head;
  logic              pop;

  // Classification and queue.
  rmq_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_data  (in_tdata),
    .pop      (pop),
    .head     (head)
  );

  // Arithmetic pipeline and output register.
  rmq_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata),
    .out_user  (out_tuser)
  );

endmodule

`default_nettype wire

### bench/rmq_checker.sv
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion: result checker
// Watches both stream channels, works out the expected quaternion for every
// accepted matrix and compares each accepted result with the oldest one.
// ----------------------------------------------------------------------------
`default_nettype none

module rmq_checker (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  input  wire logic                            in_tready,
  // basis_i_x .. basis_k_z (32 bits each, lowest first)
  input  wire logic [rmq_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  wire logic                            out_tvalid,
  input  wire logic                            out_tready,
  // quat_i, quat_j, quat_k, quat_w (32 bits each, lowest first)
  input  wire logic [rmq_pkg::OUT_TDATA_W-1:0] out_tdata,
  // branch_taken [1:0], invalid [2]
  input  wire logic [rmq_pkg::OUT_TUSER_W-1:0] out_tuser,
  output int                                   fail_count,
  output int                                   pending
);

  typedef struct packed {
    logic signed [31:0] qi, qj, qk, qw;
    rmq_pkg::branch_t   branch;
    logic               invalid;
  } quat_res_t;

  quat_res_t quat_queue[$];

  // Floor of the square root of a 128-bit value, 64-bit root.
  function automatic logic [63:0] floor_sqrt(input logic [127:0] t);
    logic [63:0]  root;
    logic [63:0]  cand;
    logic [127:0] sq;
    root = '0;
    for (int b = 63; b >= 0; b--) begin
      cand = root | (64'd1 << b);
      sq = {64'd0, cand} * {64'd0, cand};
      if (sq <= t) root = cand;
    end
    return root;
  endfunction

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // (num * 2^FRAC_BITS) / d, truncated toward zero and saturated.
  function automatic longint fix_div(input longint num, input logic [63:0] d);
    logic          neg;
    logic [63:0]   mag;
    logic [127:0]  quo;
    neg = num < 0;
    mag = neg ? 64'd0 - 64'(num) : 64'(num);
    quo = ({64'd0, mag} << rmq_pkg::FRAC_BITS) / {64'd0, d};
    if (quo > (128'd1 << 32)) quo = 128'd1 << 32;
    return clamp32(neg ? -longint'(quo[63:0]) : longint'(quo[63:0]));
  endfunction

  // Shepperd conversion of one packed matrix.
  function automatic quat_res_t rotation_to_quat(input logic [rmq_pkg::IN_TDATA_W-1:0] m);
    longint           e[9];
    longint           one, rad, half;
    longint           q[4];
    logic [63:0]      root, scale, norm_sq, nroot;
    logic [65:0]      acc;
    rmq_pkg::branch_t br;
    logic             bad;
    quat_res_t        r;
    one = longint'(1) << rmq_pkg::FRAC_BITS;
    for (int c = 0; c < 9; c++) e[c] = longint'($signed(m[c*32 +: 32]));
    bad = 1'b0;
    if (e[0] + e[4] + e[8] + one > 0) begin
      br = rmq_pkg::BR_TRACE; rad = e[0] + e[4] + e[8] + one;
    end else if (e[0] > e[4] && e[0] > e[8]) begin
      br = rmq_pkg::BR_X; rad = one + e[0] - e[4] - e[8];
    end else if (e[4] > e[8]) begin
      br = rmq_pkg::BR_Y; rad = one + e[4] - e[0] - e[8];
    end else begin
      br = rmq_pkg::BR_Z; rad = one + e[8] - e[0] - e[4];
    end
    if (rad <= 0) begin
      bad = 1'b1;
    end else begin
      root  = floor_sqrt({64'd0, 64'(rad)} << rmq_pkg::FRAC_BITS);
      scale = root * 2;
      half  = clamp32(longint'(root >> 1));
      // Element order: 0 ix, 1 iy, 2 iz, 3 jx, 4 jy, 5 jz, 6 kx, 7 ky, 8 kz.
      case (br)
        rmq_pkg::BR_TRACE: begin
          q[0] = fix_div(e[5] - e[7], scale); q[1] = fix_div(e[6] - e[2], scale);
          q[2] = fix_div(e[1] - e[3], scale); q[3] = half;
        end
        rmq_pkg::BR_X: begin
          q[0] = half; q[1] = fix_div(e[3] + e[1], scale);
          q[2] = fix_div(e[2] + e[6], scale); q[3] = fix_div(e[5] - e[7], scale);
        end
        rmq_pkg::BR_Y: begin
          q[0] = fix_div(e[3] + e[1], scale); q[1] = half;
          q[2] = fix_div(e[7] + e[5], scale); q[3] = fix_div(e[6] - e[2], scale);
        end
        default: begin
          q[0] = fix_div(e[6] + e[2], scale); q[1] = fix_div(e[7] + e[5], scale);
          q[2] = half; q[3] = fix_div(e[1] - e[3], scale);
        end
      endcase
      acc = '0;
      for (int c = 0; c < 4; c++) acc += 66'(64'(q[c] * q[c]));
      norm_sq = (acc > 66'h0_FFFF_FFFF_FFFF_FFFF) ? 64'hFFFF_FFFF_FFFF_FFFF : acc[63:0];
      if (norm_sq == 0) begin
        bad = 1'b1;
      end else if (norm_sq != (64'd1 << (2 * rmq_pkg::FRAC_BITS))) begin
        nroot = floor_sqrt({64'd0, norm_sq});
        for (int c = 0; c < 4; c++) q[c] = fix_div(q[c], nroot);
      end
    end
    if (bad) begin
      q[0] = 0; q[1] = 0; q[2] = 0; q[3] = clamp32(one);
    end
    r.qi = q[0][31:0]; r.qj = q[1][31:0]; r.qk = q[2][31:0]; r.qw = q[3][31:0];
    r.branch = br;
    r.invalid = bad;
    return r;
  endfunction

  // Predict on input items, compare on output items.
  always @(posedge clk) begin
    quat_res_t exp_r;
    quat_res_t got;
    if (!rst_n) begin
      fail_count <= 0;
      pending    <= 0;
    end else begin
      if (in_tvalid && in_tready) quat_queue.push_back(rotation_to_quat(in_tdata));
      if (out_tvalid && out_tready) begin
        got.qi = out_tdata[31:0];
        got.qj = out_tdata[63:32];
        got.qk = out_tdata[95:64];
        got.qw = out_tdata[127:96];
        got.branch = rmq_pkg::branch_t'(out_tuser[1:0]);
        got.invalid = out_tuser[2];
        if (quat_queue.size() == 0) begin
          $display("%0t: result with nothing expected: %h %h", $time, out_tdata, out_tuser);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = quat_queue.pop_front();
          if (got != exp_r) begin
            $display("%0t: mismatch expected i=%h j=%h k=%h w=%h br=%0d inv=%0b",
                     $time, exp_r.qi, exp_r.qj, exp_r.qk, exp_r.qw, exp_r.branch,
                     exp_r.invalid);
            $display("%0t:          actual   i=%h j=%h k=%h w=%h br=%0d inv=%0b",
                     $time, got.qi, got.qj, got.qk, got.qw, got.branch, got.invalid);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= quat_queue.size();
    end
  end

endmodule

`default_nettype wire

### bench/tb_rotation_matrix_to_quaternion_top.sv
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion: testbench top
// Drives directed and random matrices with random gaps and back-pressure,
// and gives the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_rotation_matrix_to_quaternion_top;

  localparam int IDLE_PCT   = 28;
  localparam int N_RANDOM   = 1530;
  localparam int STALL_LIM  = 5000;
  localparam int DRAIN_WAIT = 300;
  localparam logic signed [31:0] ONE = 32'sh4000_0000;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [rmq_pkg::IN_TDATA_W-1:0]  in_tdata = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [rmq_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic [rmq_pkg::OUT_TUSER_W-1:0] out_tuser;
  int                              fail_count;
  int                              pending;
  logic                            calm = 1'b0;
  int                              quiet_cycles = 0;

  always #1 clk = ~clk;

  rotation_matrix_to_quaternion_top i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  rmq_checker i_checker (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser),
    .fail_count(fail_count), .pending(pending)
  );

  // Receiver back-pressure.
  always @(posedge clk) begin
    out_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  // Watchdog on cycles with no accepted item on either side.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIM) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send_matrix(input logic [rmq_pkg::IN_TDATA_W-1:0] m);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= m;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  function automatic logic [rmq_pkg::IN_TDATA_W-1:0] pack9(input logic signed [31:0] v[9]);
    logic [rmq_pkg::IN_TDATA_W-1:0] m;
    for (int c = 0; c < 9; c++) m[c*32 +: 32] = v[c];
    return m;
  endfunction

  // Signed permutation matrix with optional small noise on every element.
  function automatic logic [rmq_pkg::IN_TDATA_W-1:0] perm_matrix(input int noise);
    logic signed [31:0] v[9];
    int p[3];
    int t, s;
    p = '{0, 1, 2};
    for (int c = 2; c > 0; c--) begin
      s = $urandom_range(c);
      t = p[c]; p[c] = p[s]; p[s] = t;
    end
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++) begin
        v[r*3+c] = (p[r] == c) ? ($urandom_range(1) ? ONE : -ONE) : 32'sd0;
        if (noise > 0) v[r*3+c] += $signed($urandom_range(2 * noise)) - noise;
      end
    return pack9(v);
  endfunction

  function automatic logic [rmq_pkg::IN_TDATA_W-1:0] rand_matrix(input int kind);
    logic signed [31:0] v[9];
    for (int c = 0; c < 9; c++)
      v[c] = (kind == 0) ? $urandom : $signed($urandom_range(32'h8000_0000)) - ONE;
    return pack9(v);
  endfunction

  function automatic logic [rmq_pkg::IN_TDATA_W-1:0] fill_matrix(
      input logic signed [31:0] x);
    logic signed [31:0] v[9];
    for (int c = 0; c < 9; c++) v[c] = x;
    return pack9(v);
  endfunction

  function automatic logic [rmq_pkg::IN_TDATA_W-1:0] diag_matrix(
      input logic signed [31:0] a, input logic signed [31:0] b,
      input logic signed [31:0] c);
    logic signed [31:0] v[9];
    for (int n = 0; n < 9; n++) v[n] = 32'sd0;
    v[0] = a; v[4] = b; v[8] = c;
    return pack9(v);
  endfunction

  initial begin
    int sel;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: identity (exact unit norm), each branch, ties and extremes.
    send_matrix(diag_matrix(ONE, ONE, ONE));
    send_matrix(diag_matrix(ONE, -ONE, -ONE));
    send_matrix(diag_matrix(-ONE, ONE, -ONE));
    send_matrix(diag_matrix(-ONE, -ONE, ONE));
    send_matrix(diag_matrix(-ONE, -ONE, -ONE));
    send_matrix(diag_matrix(-ONE, 32'sd0, 32'sd0));
    send_matrix(diag_matrix(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000));
    send_matrix(diag_matrix(32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000));
    send_matrix(fill_matrix(32'sd0));
    send_matrix(fill_matrix(32'sh7fff_ffff));
    send_matrix(fill_matrix(32'sh8000_0000));
    send_matrix(fill_matrix(32'shffff_ffff));
    send_matrix(fill_matrix(-ONE));
    send_matrix(fill_matrix(32'sh5555_5555));
    send_matrix(fill_matrix(32'shaaaa_aaaa));
    for (int n = 0; n < 5; n++) send_matrix(perm_matrix(0));

    // Random: mostly near-rotations, then plain and full-range noise.
    for (int n = 0; n < N_RANDOM; n++) begin
      calm <= (n >= 400 && n < 650);
      if (n == 800) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      sel = $urandom_range(99);
      if (sel < 50) send_matrix(perm_matrix(1 << $urandom_range(24)));
      else if (sel < 60) send_matrix(perm_matrix(0));
      else if (sel < 80) send_matrix(rand_matrix(1));
      else send_matrix(rand_matrix(0));
    end
    in_tvalid <= 1'b0;
    calm <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

### files.f
design/rmq_pkg.sv
design/rmq_front.sv
design/rmq_sqrt.sv
design/rmq_div.sv
design/rmq_back.sv
design/rotation_matrix_to_quaternion_top.sv
bench/rmq_checker.sv
bench/tb_rotation_matrix_to_quaternion_top.sv
